// ===== design/hpt_pkg.sv =====
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types, codes and the HID usage to PS/2 Set 1 lookup table.
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int BYTE_W    = 8;
    localparam int MAX_BYTES = 3;
    localparam int CNT_W     = 2;

    // op codes of an input item
    localparam logic OP_KEY   = 1'b0;
    localparam logic OP_MOUSE = 1'b1;

    // output stream select
    localparam logic CH_KEY   = 1'b0;
    localparam logic CH_MOUSE = 1'b1;

    localparam logic [BYTE_W-1:0] EXT_PREFIX = 8'hE0;
    localparam logic [BYTE_W-1:0] NO_CODE    = 8'h00;

    localparam logic [CNT_W-1:0] CNT_NONE  = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONE   = 2'd1;
    localparam logic [CNT_W-1:0] CNT_TWO   = 2'd2;
    localparam logic [CNT_W-1:0] CNT_THREE = 2'd3;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] usage;
        logic              press;
        logic [BYTE_W-1:0] buttons;
        logic [BYTE_W-1:0] delta_x;
        logic [BYTE_W-1:0] delta_y;
    } hpt_item_t;

    typedef struct packed {
        logic [CNT_W-1:0]                  count;
        logic                              chan;
        logic [MAX_BYTES-1:0][BYTE_W-1:0]  bytes;
    } hpt_bytes_t;

    // Set 1 make code for a HID usage; bit 7 marks an extended key,
    // zero marks an unmapped usage.
    function automatic logic [BYTE_W-1:0] usage_entry(input logic [BYTE_W-1:0] usage);
        logic [BYTE_W-1:0] e;
        case (usage)
            8'h04: e = 8'h1E;  8'h05: e = 8'h30;  8'h06: e = 8'h2E;  8'h07: e = 8'h20;
            8'h08: e = 8'h12;  8'h09: e = 8'h21;  8'h0A: e = 8'h22;  8'h0B: e = 8'h23;
            8'h0C: e = 8'h17;  8'h0D: e = 8'h24;  8'h0E: e = 8'h25;  8'h0F: e = 8'h26;
            8'h10: e = 8'h32;  8'h11: e = 8'h31;  8'h12: e = 8'h18;  8'h13: e = 8'h19;
            8'h14: e = 8'h10;  8'h15: e = 8'h13;  8'h16: e = 8'h1F;  8'h17: e = 8'h14;
            8'h18: e = 8'h16;  8'h19: e = 8'h2F;  8'h1A: e = 8'h11;  8'h1B: e = 8'h2D;
            8'h1C: e = 8'h15;  8'h1D: e = 8'h2C;
            8'h1E: e = 8'h02;  8'h1F: e = 8'h03;  8'h20: e = 8'h04;  8'h21: e = 8'h05;
            8'h22: e = 8'h06;  8'h23: e = 8'h07;  8'h24: e = 8'h08;  8'h25: e = 8'h09;
            8'h26: e = 8'h0A;  8'h27: e = 8'h0B;
            8'h28: e = 8'h1C;  8'h29: e = 8'h01;  8'h2A: e = 8'h0E;  8'h2B: e = 8'h0F;
            8'h2C: e = 8'h39;  8'h2D: e = 8'h0C;  8'h2E: e = 8'h0D;  8'h2F: e = 8'h1A;
            8'h30: e = 8'h1B;  8'h31: e = 8'h2B;  8'h33: e = 8'h27;
            8'h34: e = 8'h28;  8'h35: e = 8'h29;  8'h36: e = 8'h33;  8'h37: e = 8'h34;
            8'h38: e = 8'h35;
            8'h39: e = 8'h3A;  8'h3A: e = 8'h3B;  8'h3B: e = 8'h3C;  8'h3C: e = 8'h3D;
            8'h3D: e = 8'h3E;  8'h3E: e = 8'h3F;  8'h3F: e = 8'h40;  8'h40: e = 8'h41;
            8'h41: e = 8'h42;  8'h42: e = 8'h43;  8'h43: e = 8'h44;  8'h44: e = 8'h57;
            8'h45: e = 8'h58;
            8'h47: e = 8'h46;  8'h49: e = 8'hD2;
            8'h4A: e = 8'hC7;  8'h4B: e = 8'hC9;  8'h4C: e = 8'hD3;  8'h4D: e = 8'hCF;
            8'h4E: e = 8'hD1;  8'h4F: e = 8'hCD;  8'h50: e = 8'hCB;  8'h51: e = 8'hD0;
            8'h52: e = 8'hC8;
            8'h53: e = 8'h45;  8'h54: e = 8'hB5;  8'h55: e = 8'h37;  8'h56: e = 8'h4A;
            8'h57: e = 8'h4E;  8'h58: e = 8'h9C;  8'h59: e = 8'h4F;  8'h5A: e = 8'h50;
            8'h5B: e = 8'h51;  8'h5C: e = 8'h4B;  8'h5D: e = 8'h4C;  8'h5E: e = 8'h4D;
            8'h5F: e = 8'h47;  8'h60: e = 8'h48;  8'h61: e = 8'h49;  8'h62: e = 8'h52;
            8'h63: e = 8'h53;
            // modifiers: LCtrl LShift LAlt LGui RCtrl RShift RAlt RGui
            8'hE0: e = 8'h1D;  8'hE1: e = 8'h2A;  8'hE2: e = 8'h38;  8'hE3: e = 8'hDB;
            8'hE4: e = 8'h9D;  8'hE5: e = 8'h36;  8'hE6: e = 8'hB8;  8'hE7: e = 8'hDC;
            default: e = NO_CODE;
        endcase
        return e;
    endfunction

endpackage

// ===== design/hpt_decode.sv =====
// ----------------------------------------------------------------------------
// hpt_decode
// Turn one registered item into its list of up to three PS/2 bytes.
// ----------------------------------------------------------------------------
module hpt_decode
    import hpt_pkg::*;
(
    input  hpt_item_t  item,
    output hpt_bytes_t result
);

    logic [BYTE_W-1:0] entry;
    logic [BYTE_W-1:0] code;

    assign entry = usage_entry(item.usage);
    // clear extended marker, set break bit on release
    assign code  = {~item.press, entry[BYTE_W-2:0]};

    always_comb
    begin
        result.count = CNT_NONE;
        result.chan  = CH_KEY;
        result.bytes = '0;
        if (item.op == OP_MOUSE)
        begin
            result.count    = CNT_THREE;
            result.chan     = CH_MOUSE;
            result.bytes[0] = item.buttons;
            result.bytes[1] = item.delta_x;
            result.bytes[2] = item.delta_y;
        end
        else if (entry != NO_CODE)
        begin
            if (entry[BYTE_W-1])
            begin
                result.count    = CNT_TWO;
                result.bytes[0] = EXT_PREFIX;
                result.bytes[1] = code;
            end
            else
            begin
                result.count    = CNT_ONE;
                result.bytes[0] = code;
            end
        end
    end

endmodule

// ===== design/hid_to_ps2_set1_translator_unit.sv =====
// ----------------------------------------------------------------------------
// hid_to_ps2_set1_translator_unit
// HID key events and mouse reports in, PS/2 Set 1 bytes out, one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake              | Payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_ready    | op, usage, press, buttons, delta_x, delta_y
//  out     | out_valid / out_ready  | channel, out_byte, last
//
//  An accepted item is held in the input register, is decoded there and loads
//  the byte register, which hands out one byte per cycle while out_ready is high.
//  Bytes per item: 1 for a mapped plain key, 2 for an extended key, 3 for a
//  mouse report, none for an unmapped usage (dropped in the input register).
//  The input register reloads while the last byte of the previous item is
//  being taken, so items follow without a gap.
//  A stalled output holds the byte register and, once the input register is
//  full, drops in_ready. Reset empties both registers.
//
module hid_to_ps2_set1_translator_unit
    import hpt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     op,
    input  logic [BYTE_W-1:0]        usage,
    input  logic                     press,
    input  logic [BYTE_W-1:0]        buttons,
    input  logic signed [BYTE_W-1:0] delta_x,
    input  logic signed [BYTE_W-1:0] delta_y,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     channel,
    output logic [BYTE_W-1:0]        out_byte,
    output logic                     last
);

    // input register
    logic       in_valid_reg, in_valid_next;
    hpt_item_t  item_reg;

    // byte register: bytes left to send, shifted down as each one leaves
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic                             chan_reg;
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes_reg;

    hpt_bytes_t decoded;
    logic       out_take;
    logic       load_ok;
    logic       item_move;
    logic       in_take;

    hpt_decode u_decode (
        .item   (item_reg),
        .result (decoded)
    );

    assign out_valid = (cnt_reg != CNT_NONE);
    assign out_byte  = bytes_reg[0];
    assign channel   = chan_reg;
    assign last      = (cnt_reg == CNT_ONE);

    assign out_take  = out_valid && out_ready;
    // byte register is free now or frees up on this edge
    assign load_ok   = (cnt_reg == CNT_NONE) || (last && out_ready);
    assign item_move = in_valid_reg && load_ok;
    assign in_ready  = !in_valid_reg || item_move;
    assign in_take   = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (item_move)
            in_valid_next = 1'b0;

        cnt_next = cnt_reg;
        if (item_move)
            cnt_next = decoded.count;
        else if (out_take)
            cnt_next = cnt_reg - CNT_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= CNT_NONE;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
        end
    end

    // payload: capture on accept, load on move, shift on take
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.op      <= op;
            item_reg.usage   <= usage;
            item_reg.press   <= press;
            item_reg.buttons <= buttons;
            item_reg.delta_x <= delta_x;
            item_reg.delta_y <= delta_y;
        end
        if (item_move)
        begin
            chan_reg  <= decoded.chan;
            bytes_reg <= decoded.bytes;
        end
        else if (out_take)
        begin
            bytes_reg[0] <= bytes_reg[1];
            bytes_reg[1] <= bytes_reg[2];
        end
    end

    // a mouse report always loads three bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_move && item_reg.op == OP_MOUSE) |=> (cnt_reg == CNT_THREE && channel == CH_MOUSE))
        else $error("mouse report did not load three bytes");

    // one byte leaves per take until the item is done
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && !last) |=> (out_valid && cnt_reg == $past(cnt_reg) - CNT_ONE))
        else $error("byte count did not advance by one");

    // the stream select holds across the bytes of one item
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && !last) |=> (channel == $past(channel)))
        else $error("channel changed inside an item");

    // back pressure only while the input register holds an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && !load_ok))
        else $error("in_ready low with room to move");

    // an extended key starts with the prefix byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_move && decoded.count == CNT_TWO) |=> (out_byte == EXT_PREFIX))
        else $error("extended key without prefix");

endmodule
